### rtl/ngma_pkg.sv
// ----------------------------------------------------------------------------
// ngma_pkg: shared constants for the noise gate moving average core
// Window geometry, field widths and derived datapath widths.
// ----------------------------------------------------------------------------
package ngma_pkg;

	localparam int HALF_WINDOW = 5;
	localparam int WIN_LEN     = 2 * HALF_WINDOW + 1;

	localparam int SAMPLE_W = 16;
	localparam int THR_W    = 15;
	localparam logic [THR_W-1:0] GATE_RESET = THR_W'(20);

	// running sum holds up to WIN_LEN full scale samples
	localparam int SUM_W  = SAMPLE_W + $clog2(WIN_LEN);
	localparam int CNT_W  = $clog2(WIN_LEN + 1);
	localparam int IDX_W  = $clog2(WIN_LEN);
	localparam int HI_W   = IDX_W + 1;
	localparam int LAG_W  = $clog2(HALF_WINDOW + 1);
	localparam int DIVC_W = $clog2(SUM_W);

endpackage

### rtl/noise_gate_moving_average_core.sv
// ----------------------------------------------------------------------------
// noise_gate_moving_average_core: noise gate and centered moving average
// Gates small samples to zero and averages over a window of the same block.
// ----------------------------------------------------------------------------
// Usage:
//   s_tdata carries one signed 16-bit sample, s_tlast marks the last sample
//   of a block. m_tdata carries the smoothed sample, m_tlast the last output
//   of the block. cfg_we/cfg_wdata write the gate threshold; the user must
//   write it only at an edge the core is idle: the core does not enforce it.
//   Output k of a block appears when input k+HALF_WINDOW is taken; the input
//   with s_tlast flushes the pending outputs (up to HALF_WINDOW+1 results).
//   All arithmetic goes through one SUM_W-bit adder under a sequencer, and
//   each mean uses a restoring divider on that adder, one quotient bit a
//   cycle. An input that causes no result passes S_SUB and S_ADD only. A
//   windowed result then goes through S_ABS, S_DIV, S_NEG and S_PUT; each
//   flushed result passes S_FSUB, which drops the window entries beyond its
//   window from the sum, and then the same states. The next request is taken
//   only once the sequencer is back in S_IDLE.
//   s_tready is high only while the sequencer is idle. A finished result
//   sits in the output register; if the receiver stalls, the sequencer
//   waits before loading the next one, while an idle core still takes input.
//   Reset (arst_n low) clears the window, the sum, the counts and sets the
//   threshold to 20.
// ----------------------------------------------------------------------------
module noise_gate_moving_average_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ngma_pkg::THR_W-1:0]     cfg_wdata,   // gate_threshold
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [ngma_pkg::SAMPLE_W-1:0]  s_tdata,     // sample
	input  logic                           s_tlast,     // block_last
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [ngma_pkg::SAMPLE_W-1:0]  m_tdata,     // smoothed
	output logic                           m_tlast      // block_end
);
	import ngma_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SUB,
		S_ADD,
		S_FSUB,
		S_ABS,
		S_DIV,
		S_NEG,
		S_PUT
	} state_t;

	state_t                      state_q;
	logic [THR_W-1:0]            thr_q;
	logic signed [SAMPLE_W-1:0]  win_q [WIN_LEN];
	logic signed [SAMPLE_W-1:0]  g_q;
	logic                        last_q;
	logic [SUM_W-1:0]            sum_q;
	logic [CNT_W-1:0]            seen_q;
	logic                        flush_q;
	logic [LAG_W-1:0]            lag_q;
	logic [IDX_W-1:0]            cur_hi_q;
	logic [CNT_W-1:0]            div_q;
	logic                        end_q;
	logic                        neg_q;
	logic [SUM_W-1:0]            num_q;
	logic [SUM_W-1:0]            quo_q;
	logic [CNT_W-1:0]            rem_q;
	logic [DIVC_W-1:0]           div_cnt_q;
	logic [SAMPLE_W-1:0]         res_q;
	logic                        m_tvalid_q;
	logic [SAMPLE_W-1:0]         m_tdata_q;
	logic                        m_tlast_q;

	// noise gate on the incoming sample
	logic signed [SAMPLE_W:0]    s_ext;
	logic signed [SAMPLE_W:0]    t_ext;
	logic                        gated;
	logic signed [SAMPLE_W-1:0]  g_nxt;

	assign s_ext = {s_tdata[SAMPLE_W-1], s_tdata};
	assign t_ext = {{(SAMPLE_W + 1 - THR_W){1'b0}}, thr_q};
	assign gated = (s_ext > -t_ext) && (s_ext < t_ext);
	assign g_nxt = gated ? '0 : s_tdata;

	// shared adder
	logic [SUM_W-1:0] alu_a;
	logic [SUM_W-1:0] alu_b;
	logic             alu_sub;
	logic [SUM_W-1:0] alu_res;
	logic [CNT_W:0]   shifted;

	assign shifted = {rem_q, num_q[SUM_W-1]};

	always_comb begin
		alu_a   = sum_q;
		alu_b   = '0;
		alu_sub = 1'b0;
		case (state_q)
			S_SUB: begin
				alu_b   = SUM_W'(win_q[WIN_LEN-1]);
				alu_sub = 1'b1;
			end
			S_ADD: begin
				alu_b   = SUM_W'(g_q);
			end
			S_FSUB: begin
				alu_b   = SUM_W'(win_q[cur_hi_q]);
				alu_sub = 1'b1;
			end
			S_ABS: begin
				alu_a   = '0;
				alu_b   = sum_q;
				alu_sub = sum_q[SUM_W-1];
			end
			S_DIV: begin
				alu_a   = SUM_W'(shifted);
				alu_b   = SUM_W'(div_q);
				alu_sub = 1'b1;
			end
			S_NEG: begin
				alu_a   = '0;
				alu_b   = quo_q;
				alu_sub = neg_q;
			end
			default: begin
				alu_a   = sum_q;
			end
		endcase
	end

	assign alu_res = alu_a + (alu_sub ? ~alu_b : alu_b) + SUM_W'(alu_sub);

	// sample count after this step, and flush bookkeeping
	logic [CNT_W-1:0] seen_nxt;
	logic [LAG_W-1:0] lag_init;
	logic [HI_W-1:0]  lag_h;
	logic [HI_W-1:0]  seen_m1;
	logic [HI_W-1:0]  flush_hi;
	logic [CNT_W-1:0] flush_cnt;
	logic             drop_more;
	logic             out_free;

	always_comb begin
		seen_nxt = seen_q;
		if (state_q == S_ADD && seen_q != CNT_W'(WIN_LEN)) begin
			seen_nxt = seen_q + CNT_W'(1);
		end
	end

	assign lag_init  = (seen_nxt < CNT_W'(HALF_WINDOW)) ? LAG_W'(seen_nxt - CNT_W'(1))
	                                                   : LAG_W'(HALF_WINDOW - 1);
	assign lag_h     = HI_W'(lag_q) + HI_W'(HALF_WINDOW);
	assign seen_m1   = HI_W'(seen_q) - HI_W'(1);
	assign flush_hi  = (lag_h < seen_m1) ? lag_h : seen_m1;
	assign flush_cnt = CNT_W'(flush_hi + HI_W'(1));
	assign drop_more = HI_W'(cur_hi_q) > lag_h;
	assign out_free  = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			thr_q      <= GATE_RESET;
			for (int i = 0; i < WIN_LEN; i++) begin
				win_q[i] <= '0;
			end
			g_q        <= '0;
			last_q     <= 1'b0;
			sum_q      <= '0;
			seen_q     <= '0;
			flush_q    <= 1'b0;
			lag_q      <= '0;
			cur_hi_q   <= '0;
			div_q      <= '0;
			end_q      <= 1'b0;
			neg_q      <= 1'b0;
			num_q      <= '0;
			quo_q      <= '0;
			rem_q      <= '0;
			div_cnt_q  <= '0;
			res_q      <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tlast_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
			// the output register is loaded only in S_PUT
			if (m_tready && state_q != S_PUT) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						g_q     <= g_nxt;
						last_q  <= s_tlast;
						state_q <= S_SUB;
					end
				end
				S_SUB: begin
					sum_q   <= alu_res;
					state_q <= S_ADD;
				end
				S_ADD: begin
					sum_q    <= alu_res;
					win_q[0] <= g_q;
					for (int i = 1; i < WIN_LEN; i++) begin
						win_q[i] <= win_q[i-1];
					end
					seen_q <= seen_nxt;
					if (seen_nxt > CNT_W'(HALF_WINDOW)) begin
						div_q   <= seen_nxt;
						end_q   <= 1'b0;
						state_q <= S_ABS;
					end else if (last_q) begin
						flush_q  <= 1'b1;
						lag_q    <= lag_init;
						cur_hi_q <= IDX_W'(WIN_LEN - 1);
						state_q  <= S_FSUB;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_FSUB: begin
					// walk the running sum down to entries 0..lag+HALF_WINDOW
					if (drop_more) begin
						sum_q    <= alu_res;
						cur_hi_q <= cur_hi_q - IDX_W'(1);
					end else begin
						div_q   <= flush_cnt;
						end_q   <= (lag_q == '0);
						state_q <= S_ABS;
					end
				end
				S_ABS: begin
					neg_q     <= sum_q[SUM_W-1];
					num_q     <= alu_res;
					quo_q     <= '0;
					rem_q     <= '0;
					div_cnt_q <= DIVC_W'(SUM_W - 1);
					state_q   <= S_DIV;
				end
				S_DIV: begin
					// restoring step: keep the difference when it did not go negative
					if (!alu_res[SUM_W-1]) begin
						rem_q <= alu_res[CNT_W-1:0];
					end else begin
						rem_q <= shifted[CNT_W-1:0];
					end
					quo_q <= {quo_q[SUM_W-2:0], !alu_res[SUM_W-1]};
					num_q <= {num_q[SUM_W-2:0], 1'b0};
					if (div_cnt_q == '0) begin
						state_q <= S_NEG;
					end else begin
						div_cnt_q <= div_cnt_q - DIVC_W'(1);
					end
				end
				S_NEG: begin
					res_q   <= alu_res[SAMPLE_W-1:0];
					state_q <= S_PUT;
				end
				S_PUT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= res_q;
						m_tlast_q  <= end_q;
						if (flush_q) begin
							if (lag_q == '0) begin
								for (int i = 0; i < WIN_LEN; i++) begin
									win_q[i] <= '0;
								end
								sum_q   <= '0;
								seen_q  <= '0;
								flush_q <= 1'b0;
								state_q <= S_IDLE;
							end else begin
								lag_q   <= lag_q - LAG_W'(1);
								state_q <= S_FSUB;
							end
						end else if (last_q) begin
							flush_q  <= 1'b1;
							lag_q    <= lag_init;
							cur_hi_q <= IDX_W'(WIN_LEN - 1);
							state_q  <= S_FSUB;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	// one request at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken while a sample is still in work");

	a_seen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= CNT_W'(WIN_LEN))
		else $error("sample count beyond window length");

	// the flush walk never drops below the entries it still needs
	a_flush_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FSUB) |-> (HI_W'(cur_hi_q) >= lag_h))
		else $error("flush sum walked past its window");

	a_block_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && seen_q == '0) |-> (sum_q == '0 && !flush_q))
		else $error("block starts with a stale sum");

endmodule
